// ===== design/fls_pkg.sv =====
// shared types, constants and lookup functions for the fps load-shed level controller
package fls_pkg;

  localparam int unsigned RateW  = 12;
  localparam int unsigned TimeW  = 32;
  localparam int unsigned DwellW = 16;
  localparam int unsigned LevelW = 2;
  localparam int unsigned IvalW  = 9;
  localparam int unsigned CfgIdxW  = 8;
  localparam int unsigned CfgDataW = 16;

  localparam logic [LevelW-1:0] LevelMax = 2'd2;

  localparam logic [RateW-1:0]  OnRateRst   = 12'd320;
  localparam logic [RateW-1:0]  OffRateRst  = 12'd400;
  localparam logic [DwellW-1:0] StepDwellRst  = 16'd2000;
  localparam logic [DwellW-1:0] ClearDwellRst = 16'd5000;

  localparam logic [IvalW-1:0] DetectLvl1 = 9'd120;
  localparam logic [IvalW-1:0] DetectLvl2 = 9'd300;
  localparam logic [IvalW-1:0] LinkLvl1   = 9'd160;
  localparam logic [IvalW-1:0] LinkLvl2   = 9'd400;

  typedef enum logic [CfgIdxW-1:0] {
    REG_THROTTLE_ON_RATE  = 8'd0,
    REG_THROTTLE_OFF_RATE = 8'd1,
    REG_STEP_UP_DWELL_MS  = 8'd2,
    REG_CLEAR_DWELL_MS    = 8'd3
  } fls_reg_e;

  typedef struct packed {
    logic [RateW-1:0] rate_q4;
    logic [TimeW-1:0] time_ms;
  } fls_in_t;

  typedef struct packed {
    logic [LevelW-1:0] throttle_level;
    logic [IvalW-1:0]  detect_interval_ms;
    logic [IvalW-1:0]  link_interval_ms;
    logic              throttled;
  } fls_out_t;

  typedef struct packed {
    logic [RateW-1:0]  throttle_on_rate;
    logic [RateW-1:0]  throttle_off_rate;
    logic [DwellW-1:0] step_up_dwell_ms;
    logic [DwellW-1:0] clear_dwell_ms;
  } fls_cfg_t;

  function automatic logic [IvalW-1:0] detect_for_level(input logic [LevelW-1:0] lv);
    logic [IvalW-1:0] r;
    if (lv == '0) r = '0;
    else if (lv == 2'd1) r = DetectLvl1;
    else r = DetectLvl2;
    return r;
  endfunction

  function automatic logic [IvalW-1:0] link_for_level(input logic [LevelW-1:0] lv);
    logic [IvalW-1:0] r;
    if (lv == '0) r = '0;
    else if (lv == 2'd1) r = LinkLvl1;
    else r = LinkLvl2;
    return r;
  endfunction

endpackage

// ===== design/fps_load_shed_level_controller.sv =====
// top level of the fps load-shed level controller
// an accepted input beat is registered in the input reg, then its result in the result reg
// one beat per cycle unless stalled; level and timer state update in one pass between regs
// stall_o rises only when the input reg is full and the result reg is full and stalled
// reset: async active low; level 0, both timers stopped, config back to defaults
// config registers are written with no wait state (ready held high)
module fps_load_shed_level_controller
  import fls_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  // input report beats
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  fls_in_t             in_data_i,
  // result beats
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output fls_out_t            out_data_o,
  // config write channel
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  // live threshold and dwell settings
  fls_cfg_t cfg;

  // register file; writes outside the four defined indexes are dropped
  fls_cfg_regs u_cfg_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // two-register datapath: report in, band check and dwell compare, result out
  fls_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

// ===== design/fls_cfg_regs.sv =====
// configuration register file for the load-shed controller
module fls_cfg_regs
  import fls_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  output fls_cfg_t            cfg_o
);

  fls_cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_THROTTLE_ON_RATE:  cfg_d.throttle_on_rate  = cfg_data_i[RateW-1:0];
        REG_THROTTLE_OFF_RATE: cfg_d.throttle_off_rate = cfg_data_i[RateW-1:0];
        REG_STEP_UP_DWELL_MS:  cfg_d.step_up_dwell_ms  = cfg_data_i[DwellW-1:0];
        REG_CLEAR_DWELL_MS:    cfg_d.clear_dwell_ms    = cfg_data_i[DwellW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.throttle_on_rate  <= OnRateRst;
      cfg_q.throttle_off_rate <= OffRateRst;
      cfg_q.step_up_dwell_ms  <= StepDwellRst;
      cfg_q.clear_dwell_ms    <= ClearDwellRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== design/fls_core.sv =====
// input register, level/timer state update and result register
module fls_core
  import fls_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  fls_cfg_t cfg_i,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  fls_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output fls_out_t out_data_o
);

  logic              s1_valid_q;
  fls_in_t           s1_q;
  logic              out_valid_q;
  fls_out_t          out_q, out_d;
  logic [LevelW-1:0] level_q, level_d;
  logic [TimeW-1:0]  low_since_q, low_since_d;
  logic [TimeW-1:0]  high_since_q, high_since_d;
  logic [TimeW-1:0]  low_elapsed, high_elapsed;
  logic              out_free, s1_adv, in_acc;

  // output slot frees when empty or being taken
  assign out_free   = !out_valid_q || !out_stall_i;
  assign s1_adv     = s1_valid_q && out_free;
  assign in_stall_o = s1_valid_q && !out_free;
  assign in_acc     = in_valid_i && !in_stall_o;

  assign low_elapsed  = s1_q.time_ms - low_since_q;
  assign high_elapsed = s1_q.time_ms - high_since_q;

  always_comb begin
    level_d      = level_q;
    low_since_d  = low_since_q;
    high_since_d = high_since_q;
    if (s1_q.rate_q4 < cfg_i.throttle_on_rate) begin
      high_since_d = '0;
      if (low_since_q == '0) begin
        low_since_d = s1_q.time_ms;
      end else if (low_elapsed >= {{(TimeW-DwellW){1'b0}}, cfg_i.step_up_dwell_ms}) begin
        if (level_q < LevelMax) level_d = level_q + 2'd1;
        low_since_d = s1_q.time_ms;
      end
    end else if (s1_q.rate_q4 >= cfg_i.throttle_off_rate) begin
      low_since_d = '0;
      if (high_since_q == '0) begin
        high_since_d = s1_q.time_ms;
      end else if (high_elapsed >= {{(TimeW-DwellW){1'b0}}, cfg_i.clear_dwell_ms}) begin
        level_d      = '0;
        high_since_d = s1_q.time_ms;
      end
    end else begin
      low_since_d  = '0;
      high_since_d = '0;
    end
  end

  always_comb begin
    out_d.throttle_level     = level_d;
    out_d.detect_interval_ms = detect_for_level(level_d);
    out_d.link_interval_ms   = link_for_level(level_d);
    out_d.throttled          = (level_d != '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q   <= 1'b0;
      out_valid_q  <= 1'b0;
      level_q      <= '0;
      low_since_q  <= '0;
      high_since_q <= '0;
    end else begin
      if (in_acc) s1_valid_q <= 1'b1;
      else if (s1_adv) s1_valid_q <= 1'b0;
      if (s1_adv) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
      if (s1_adv) begin
        level_q      <= level_d;
        low_since_q  <= low_since_d;
        high_since_q <= high_since_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) s1_q <= in_data_i;
    if (s1_adv) out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_level_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    level_q <= LevelMax) else $error("level out of range");

  a_timers_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !((low_since_q != '0) && (high_since_q != '0))) else $error("both timers running");

  a_flag_matches: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_q.throttled == (out_q.throttle_level != '0)))
    else $error("throttled flag mismatch");

  a_adv_fills_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_adv |=> (out_valid_q && out_q.throttle_level == level_q))
    else $error("result not captured");

endmodule
